FILE: sv/rth_pkg.sv
// Shared types and constants for the RGB to HSL pixel converter.
`timescale 1ns / 1ps

package rth_pkg;

	localparam int CH_W   = 8;
	localparam int SUM_W  = CH_W + 1;
	localparam int NUM_W  = 11;
	localparam int DIV_W  = 19;
	localparam int QUO_W  = 8;
	localparam int STEPS  = 2;
	localparam int NSTAGE = QUO_W / STEPS;
	localparam int DATA_W = 3 * CH_W;
	localparam int FRONT_STAGES = 2;
	localparam int DEPTH  = FRONT_STAGES + NSTAGE;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// Partial state of one restoring division as it moves down the pipeline.
	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] dsr;
		logic [QUO_W-1:0] quo;
	} div_op_t;

endpackage

FILE: sv/rth_front.sv
// Front stages: channel max/min, hue sector numerator and divider operands.
`timescale 1ns / 1ps

module rth_front import rth_pkg::*; (
	input  logic            clk,
	input  logic            ce,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	output div_op_t         hue_op,
	output div_op_t         sat_op,
	output logic [CH_W-1:0] lightness
);

	logic [CH_W-1:0]  mx, mn;
	sector_t          sec;
	logic [CH_W-1:0]  d_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [CH_W-1:0]  r_s1, g_s1, b_s1;
	sector_t          sec_s1;

	logic [NUM_W-1:0] d_w, num;
	logic [SUM_W-1:0] den_w;
	logic [DIV_W-1:0] hue_dvd, hue_dsr, sat_dvd, sat_dsr;
	div_op_t          hue_s2, sat_s2;
	logic [CH_W-1:0]  lig_s2;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx)  mx = blue;
		if (green < mn) mn = green;
		if (blue < mn)  mn = blue;
		// Red wins a tie for the maximum, then green.
		if (red >= green && red >= blue) begin
			sec = SEC_RED;
		end else if (green >= blue) begin
			sec = SEC_GREEN;
		end else begin
			sec = SEC_BLUE;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			d_s1   <= mx - mn;
			sum_s1 <= {1'b0, mx} + {1'b0, mn};
			r_s1   <= red;
			g_s1   <= green;
			b_s1   <= blue;
			sec_s1 <= sec;
		end
	end

	always_comb begin
		d_w = {{(NUM_W-CH_W){1'b0}}, d_s1};
		case (sec_s1)
			SEC_RED: begin
				if (g_s1 >= b_s1) begin
					num = {{(NUM_W-CH_W){1'b0}}, g_s1 - b_s1};
				end else begin
					num = (d_w << 2) + (d_w << 1) - {{(NUM_W-CH_W){1'b0}}, b_s1 - g_s1};
				end
			end
			SEC_GREEN: begin
				num = (d_w << 1) + {{(NUM_W-CH_W){1'b0}}, b_s1}
					- {{(NUM_W-CH_W){1'b0}}, r_s1};
			end
			default: begin
				num = (d_w << 2) + {{(NUM_W-CH_W){1'b0}}, r_s1}
					- {{(NUM_W-CH_W){1'b0}}, g_s1};
			end
		endcase

		if (sum_s1 < SUM_W'(255)) begin
			den_w = sum_s1;
		end else begin
			den_w = SUM_W'(510) - sum_s1;
		end

		// Multiply by 255 as a shift and subtract; the divisors start aligned
		// to the top quotient bit.
		hue_dvd = ({{(DIV_W-NUM_W){1'b0}}, num} << 8) - {{(DIV_W-NUM_W){1'b0}}, num};
		hue_dsr = ({{(DIV_W-NUM_W){1'b0}}, d_w} << 9) + ({{(DIV_W-NUM_W){1'b0}}, d_w} << 8);
		sat_dvd = ({{(DIV_W-CH_W){1'b0}}, d_s1} << 8) - {{(DIV_W-CH_W){1'b0}}, d_s1};
		sat_dsr = {{(DIV_W-SUM_W){1'b0}}, den_w} << (QUO_W - 1);

		// A gray pixel divides zero by one so both quotients come out zero.
		if (d_s1 == '0) begin
			hue_dvd = '0;
			sat_dvd = '0;
			hue_dsr = DIV_W'(1) << (QUO_W - 1);
			sat_dsr = DIV_W'(1) << (QUO_W - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			hue_s2 <= '{rem: hue_dvd, dsr: hue_dsr, quo: '0};
			sat_s2 <= '{rem: sat_dvd, dsr: sat_dsr, quo: '0};
			lig_s2 <= sum_s1[SUM_W-1:1];
		end
	end

	assign hue_op    = hue_s2;
	assign sat_op    = sat_s2;
	assign lightness = lig_s2;

endmodule

FILE: sv/rth_div_stage.sv
// One divider pipeline stage: two restoring quotient bits, then a register.
`timescale 1ns / 1ps

module rth_div_stage import rth_pkg::*; (
	input  logic    clk,
	input  logic    ce,
	input  div_op_t op_in,
	output div_op_t op_out
);

	div_op_t nxt;
	div_op_t op_s1;

	always_comb begin
		nxt = op_in;
		for (int i = 0; i < STEPS; i++) begin
			if (nxt.rem >= nxt.dsr) begin
				nxt.rem = nxt.rem - nxt.dsr;
				nxt.quo = {nxt.quo[QUO_W-2:0], 1'b1};
			end else begin
				nxt.quo = {nxt.quo[QUO_W-2:0], 1'b0};
			end
			nxt.dsr = nxt.dsr >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			op_s1 <= nxt;
		end
	end

	assign op_out = op_s1;

endmodule

FILE: sv/rth_div.sv
// Pipelined restoring divider producing an 8-bit quotient over four stages.
`timescale 1ns / 1ps

module rth_div import rth_pkg::*; (
	input  logic             clk,
	input  logic             ce,
	input  div_op_t          op_in,
	output logic [QUO_W-1:0] quo
);

	div_op_t chain [NSTAGE+1];

	assign chain[0] = op_in;

	for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
		rth_div_stage u_stage (
			.clk    (clk),
			.ce     (ce),
			.op_in  (chain[k]),
			.op_out (chain[k+1])
		);
	end

	assign quo = chain[NSTAGE].quo;

endmodule

FILE: sv/rgb_to_hsl_pixel.sv
// Top level of the RGB to HSL pixel converter.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | s_tdata: red[7:0], green[15:8], blue[23:16]
//  m_axis   | out       | m_tdata: hue[7:0], saturation[15:8], lightness[23:16]
//
// One pixel enters per clock while the pipeline advances; it passes two front stages and
// four divider stages of two quotient bits each, the last one feeding m_tdata.
// The whole pipeline advances together whenever the output beat is empty or
// taken, so s_tready follows m_tready while the output holds a beat.
// arst_n clears only the valid bits; data registers are not reset.
`timescale 1ns / 1ps

module rgb_to_hsl_pixel import rth_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // red, green, blue
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata    // hue, saturation, lightness
);

	logic             ce;
	logic [DEPTH-1:0] vld_q;
	div_op_t          hue_op, sat_op;
	logic [CH_W-1:0]  lig_front;
	logic [CH_W-1:0]  lig_pipe [NSTAGE];
	logic [QUO_W-1:0] hue_quo, sat_quo;

	assign ce       = ~vld_q[DEPTH-1] | m_tready;
	assign s_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	rth_front u_front (
		.clk       (clk),
		.ce        (ce),
		.red       (s_tdata[CH_W-1:0]),
		.green     (s_tdata[2*CH_W-1:CH_W]),
		.blue      (s_tdata[3*CH_W-1:2*CH_W]),
		.hue_op    (hue_op),
		.sat_op    (sat_op),
		.lightness (lig_front)
	);

	rth_div u_hue_div (
		.clk   (clk),
		.ce    (ce),
		.op_in (hue_op),
		.quo   (hue_quo)
	);

	rth_div u_sat_div (
		.clk   (clk),
		.ce    (ce),
		.op_in (sat_op),
		.quo   (sat_quo)
	);

	always_ff @(posedge clk) begin
		if (ce) begin
			lig_pipe[0] <= lig_front;
			for (int k = 1; k < NSTAGE; k++) begin
				lig_pipe[k] <= lig_pipe[k-1];
			end
		end
	end

	assign m_tvalid = vld_q[DEPTH-1];
	assign m_tdata  = {lig_pipe[NSTAGE-1], sat_quo, hue_quo};

endmodule

FILE: sv/rth_checker.sv
// Port-level checker for the RGB to HSL pixel converter, bound to the top level.
`timescale 1ns / 1ps

module rth_checker import rth_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	// A held output beat stays valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// A held output beat keeps its data.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output beat changed while stalled");

	// Input is refused only while a finished beat waits to be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// Zero saturation means a gray pixel, whose hue is zero too.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2*CH_W-1:CH_W] == '0 |-> m_tdata[CH_W-1:0] == '0)
		else $error("nonzero hue on a gray pixel");

endmodule

bind rgb_to_hsl_pixel rth_checker u_rth_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
